### rtl/assert_macros.svh
// Assertion macros for the six-step commutator RTL.
// Define ASSERT_OFF to compile every check down to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Condition must hold on every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: label");
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/bldc_pkg.sv
// Shared types and constants for the six-step BLDC commutator.
// No dependencies; used by the top level and its port list.
`default_nettype none

package bldc_pkg;

    localparam int TIME_BITS   = 32;
    localparam int LEVEL_BITS  = 16;

    localparam int TIME_W      = 32;
    localparam int LEVEL_W     = 16;
    localparam int PATTERN_W   = 18;
    localparam int ANGLE_W     = 12;
    localparam int SEL_W       = 3;
    localparam int SPEED_W     = 21;
    localparam int CFG_IDX_W   = 2;

    localparam logic [ANGLE_W-1:0] ANGLE_FULL   = 12'd3600;
    localparam logic [ANGLE_W-1:0] ANGLE_STEP   = 12'd18;
    localparam logic [ANGLE_W-1:0] ANGLE_ALIGN  = 12'd300;
    localparam logic [ANGLE_W-1:0] SECTOR_WIDTH = 12'd600;
    localparam logic [SPEED_W-1:0] SPEED_NUM    = 21'd1800000;
    localparam logic [SEL_W-1:0]   LAST_STEP    = 3'd5;

    typedef enum logic [1:0] {
        FUNC_PULSE     = 2'd0,
        FUNC_TICK      = 2'd1,
        FUNC_ALIGN     = 2'd2,
        FUNC_COMMUTATE = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH_SIDE   = 2'd0,
        CFG_ENABLE      = 2'd1,
        CFG_DRIVE_LEVEL = 2'd2,
        CFG_FULL_LEVEL  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_func               func;
        logic [TIME_W-1:0]   time_us;
        logic                direction;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_W-1:0]  phase_a_level;
        logic [LEVEL_W-1:0]  phase_b_level;
        logic [LEVEL_W-1:0]  phase_c_level;
        logic                enable_a;
        logic                enable_b;
        logic                enable_c;
        logic [ANGLE_W-1:0]  angle_tenths;
        logic [SEL_W-1:0]    sector;
        logic [SPEED_W-1:0]  speed_dps;
        logic [SEL_W-1:0]    step;
    } t_out_item;

endpackage

`default_nettype wire

### rtl/bldc_six_step_commutator.sv
// Six-step BLDC commutator with a bit-serial speed divider.
// An encoder pulse with nonzero elapsed time runs the divider (S_DIV), one quotient bit per
// cycle, before S_DONE; every other event goes straight from S_IDLE to S_DONE.
// A new event is taken the cycle after the previous result is loaded into the output
// register, and an output stall holds that load.
// Reset (i_rst_n low, synchronous) clears angle, time, speed, step and drive outputs and
// loads the level registers with 400 and 1000.
`default_nettype none

`include "assert_macros.svh"

module bldc_six_step_commutator (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  bldc_pkg::t_in_item                i_in,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output bldc_pkg::t_out_item               o_out,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [bldc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [bldc_pkg::PATTERN_W-1:0]     i_cfg_data
);
    import bldc_pkg::*;

    localparam int CNT_W = $clog2(SPEED_W + 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(SPEED_W - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic [PATTERN_W-1:0]   r_high_pat;
    logic [PATTERN_W-1:0]   r_ena_pat;
    logic [LEVEL_BITS-1:0]  r_drive_lvl;
    logic [LEVEL_BITS-1:0]  r_full_lvl;

    logic [ANGLE_W-1:0]     r_angle;
    logic [TIME_BITS-1:0]   r_last;
    logic [SPEED_W-1:0]     r_speed;
    logic [SEL_W-1:0]       r_step;
    logic [LEVEL_BITS-1:0]  r_lvl [3];
    logic [2:0]             r_ena;

    // divider: r_num shifts the dividend out and the quotient in
    logic [TIME_BITS-1:0]   r_dt;
    logic [TIME_BITS-1:0]   r_rem;
    logic [SPEED_W-1:0]     r_num;
    logic [CNT_W-1:0]       r_cnt;

    logic                   in_acc;
    logic                   cfg_acc;
    logic                   out_free;
    logic [TIME_BITS-1:0]   n_dt;
    logic [ANGLE_W-1:0]     angle_sum;
    logic [ANGLE_W-1:0]     n_angle;
    logic [SEL_W-1:0]       cur_sector;
    logic [SEL_W-1:0]       n_comm_step;
    logic [SEL_W-1:0]       n_tick_step;
    logic [2:0]             comm_high;
    logic [2:0]             comm_ena;
    logic [2:0]             tick_high;
    logic [2:0]             tick_ena;
    logic [TIME_BITS:0]     trial;
    logic [TIME_BITS:0]     diff;
    logic                   q_bit;
    logic [TIME_BITS-1:0]   n_rem;

    function automatic logic [SEL_W-1:0] sector_of(input logic [ANGLE_W-1:0] a);
        sector_of = SEL_W'(a >= SECTOR_WIDTH)
                  + SEL_W'(a >= ANGLE_W'(2 * 600))
                  + SEL_W'(a >= ANGLE_W'(3 * 600))
                  + SEL_W'(a >= ANGLE_W'(4 * 600))
                  + SEL_W'(a >= ANGLE_W'(5 * 600));
    endfunction

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid & o_cfg_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid & o_in_ready;
    assign out_free    = ~r_out_valid | i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_dt       = i_in.time_us[TIME_BITS-1:0] - r_last;
        angle_sum  = r_angle + ANGLE_STEP;
        n_angle    = (angle_sum >= ANGLE_FULL) ? (angle_sum - ANGLE_FULL) : angle_sum;
        cur_sector = sector_of(r_angle);
        if (i_in.direction) begin
            n_comm_step = (cur_sector == LAST_STEP) ? '0 : cur_sector + 1'b1;
        end else begin
            n_comm_step = (cur_sector == '0) ? LAST_STEP : cur_sector - 1'b1;
        end
        n_tick_step = (r_step == LAST_STEP) ? '0 : r_step + 1'b1;
        comm_high   = r_high_pat[3 * n_comm_step +: 3];
        comm_ena    = r_ena_pat[3 * n_comm_step +: 3];
        tick_high   = r_high_pat[3 * r_step +: 3];
        tick_ena    = r_ena_pat[3 * r_step +: 3];
        trial       = {r_rem, r_num[SPEED_W-1]};
        diff        = trial - {1'b0, r_dt};
        q_bit       = (trial >= {1'b0, r_dt});
        n_rem       = q_bit ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_high_pat  <= '0;
            r_ena_pat   <= '0;
            r_drive_lvl <= LEVEL_BITS'(400);
            r_full_lvl  <= LEVEL_BITS'(1000);
            r_angle     <= '0;
            r_last      <= '0;
            r_speed     <= '0;
            r_step      <= '0;
            r_lvl[0]    <= '0;
            r_lvl[1]    <= '0;
            r_lvl[2]    <= '0;
            r_ena       <= '0;
        end else begin
            if (cfg_acc) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_HIGH_SIDE:   r_high_pat  <= i_cfg_data;
                    CFG_ENABLE:      r_ena_pat   <= i_cfg_data;
                    CFG_DRIVE_LEVEL: r_drive_lvl <= i_cfg_data[LEVEL_BITS-1:0];
                    CFG_FULL_LEVEL:  r_full_lvl  <= i_cfg_data[LEVEL_BITS-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_DONE;
                        unique case (i_in.func)
                            FUNC_PULSE: begin
                                r_angle <= n_angle;
                                r_last  <= i_in.time_us[TIME_BITS-1:0];
                                if (n_dt == '0) begin
                                    r_speed <= SPEED_NUM;
                                end else begin
                                    r_dt    <= n_dt;
                                    r_rem   <= '0;
                                    r_num   <= SPEED_NUM;
                                    r_cnt   <= '0;
                                    r_state <= S_DIV;
                                end
                            end
                            FUNC_TICK: begin
                                r_lvl[0] <= tick_high[0] ? r_full_lvl : '0;
                                r_lvl[1] <= tick_high[1] ? r_full_lvl : '0;
                                r_lvl[2] <= tick_high[2] ? r_full_lvl : '0;
                                r_ena    <= tick_ena;
                                r_step   <= n_tick_step;
                            end
                            FUNC_ALIGN: begin
                                r_angle  <= ANGLE_ALIGN;
                                r_lvl[0] <= '0;
                                r_lvl[1] <= r_full_lvl;
                                r_lvl[2] <= '0;
                                r_ena    <= '0;
                            end
                            FUNC_COMMUTATE: begin
                                r_step   <= n_comm_step;
                                r_lvl[0] <= comm_high[0] ? r_drive_lvl : '0;
                                r_lvl[1] <= comm_high[1] ? r_drive_lvl : '0;
                                r_lvl[2] <= comm_high[2] ? r_drive_lvl : '0;
                                r_ena    <= comm_ena;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    // one quotient bit per cycle, restoring division
                    r_rem <= n_rem;
                    r_num <= {r_num[SPEED_W-2:0], q_bit};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_speed <= {r_num[SPEED_W-2:0], q_bit};
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold the result until the output register frees up
                    if (out_free) begin
                        r_out.phase_a_level <= LEVEL_W'(r_lvl[0]);
                        r_out.phase_b_level <= LEVEL_W'(r_lvl[1]);
                        r_out.phase_c_level <= LEVEL_W'(r_lvl[2]);
                        r_out.enable_a      <= r_ena[0];
                        r_out.enable_b      <= r_ena[1];
                        r_out.enable_c      <= r_ena[2];
                        r_out.angle_tenths  <= r_angle;
                        r_out.sector        <= cur_sector;
                        r_out.speed_dps     <= r_speed;
                        r_out.step          <= r_step;
                        r_out_valid         <= 1'b1;
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, in_acc, r_state != S_IDLE)
    `ASSERT_SAME(a_div_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_dt != '0)
    `ASSERT_SAME(a_div_count, i_clk, i_rst_n, r_state == S_DIV, r_cnt <= DIV_LAST)
    `ASSERT_SAME(a_out_range, i_clk, i_rst_n, o_out_valid, (o_out.step <= LAST_STEP) && (o_out.sector <= LAST_STEP) && (o_out.angle_tenths < ANGLE_FULL))

endmodule

`default_nettype wire

### test/tb_bldc_six_step_commutator.sv
// Self-checking testbench for bldc_six_step_commutator: directed and random events,
// random handshake gaps, and a scoreboard class that predicts every result.
// Depends on rtl/bldc_pkg.sv and the commutator RTL only.
module tb_bldc_six_step_commutator;
    import bldc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 30;
    localparam int PHASE_EVENTS  = 150;
    localparam int NUM_PHASES    = 5;

    // Predicts the commutator's outputs and holds the results still owed by the block.
    class commutator_scoreboard;
        logic [PATTERN_W-1:0] high_side_tab;
        logic [PATTERN_W-1:0] enable_tab;
        logic [LEVEL_W-1:0]   drive_lvl;
        logic [LEVEL_W-1:0]   full_lvl;
        logic [ANGLE_W-1:0]   angle;
        logic [TIME_W-1:0]    last_pulse;
        logic [SPEED_W-1:0]   speed;
        logic [SEL_W-1:0]     step;
        logic [LEVEL_W-1:0]   lvl[3];
        logic                 ena[3];
        t_out_item            owed_q[$];
        int                   errors;
        int                   results;
        int                   func_count[4];

        function void reset_state();
            high_side_tab = '0;
            enable_tab    = '0;
            drive_lvl     = 16'd400;
            full_lvl      = 16'd1000;
            angle         = '0;
            last_pulse    = '0;
            speed         = '0;
            step          = '0;
            for (int p = 0; p < 3; p++) begin
                lvl[p] = '0;
                ena[p] = 1'b0;
            end
            owed_q.delete();
            errors  = 0;
            results = 0;
            for (int f = 0; f < 4; f++) func_count[f] = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [PATTERN_W-1:0] data);
            case (idx)
                CFG_HIGH_SIDE:   high_side_tab = data;
                CFG_ENABLE:      enable_tab    = data;
                CFG_DRIVE_LEVEL: drive_lvl     = data[LEVEL_W-1:0];
                CFG_FULL_LEVEL:  full_lvl      = data[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        function void load_drive(logic [SEL_W-1:0] s, logic [LEVEL_W-1:0] level);
            int base;
            base = int'(s) * 3;
            for (int p = 0; p < 3; p++) begin
                lvl[p] = high_side_tab[base + p] ? level : '0;
                ena[p] = enable_tab[base + p];
            end
        endfunction

        function void note_input(t_in_item it);
            int           a;
            int           sec;
            logic [31:0]  dt;
            t_out_item    exp_item;
            func_count[it.func]++;
            case (it.func)
                FUNC_PULSE: begin
                    a = int'(angle) + int'(ANGLE_STEP);
                    if (a >= int'(ANGLE_FULL)) a = a - int'(ANGLE_FULL);
                    angle = a[ANGLE_W-1:0];
                    dt = it.time_us - last_pulse;
                    // saturate when no time has passed
                    speed = (dt == 0) ? SPEED_NUM : SPEED_W'(32'(SPEED_NUM) / dt);
                    last_pulse = it.time_us;
                end
                FUNC_TICK: begin
                    load_drive(step, full_lvl);
                    step = (step == LAST_STEP) ? '0 : step + 1'b1;
                end
                FUNC_ALIGN: begin
                    angle  = ANGLE_ALIGN;
                    lvl[0] = '0;
                    lvl[1] = full_lvl;
                    lvl[2] = '0;
                    for (int p = 0; p < 3; p++) ena[p] = 1'b0;
                end
                default: begin
                    sec  = int'(angle) / int'(SECTOR_WIDTH);
                    sec  = it.direction ? (sec + 1) % 6 : (sec + 5) % 6;
                    step = sec[SEL_W-1:0];
                    load_drive(step, drive_lvl);
                end
            endcase
            sec = int'(angle) / int'(SECTOR_WIDTH);
            exp_item.phase_a_level = lvl[0];
            exp_item.phase_b_level = lvl[1];
            exp_item.phase_c_level = lvl[2];
            exp_item.enable_a      = ena[0];
            exp_item.enable_b      = ena[1];
            exp_item.enable_c      = ena[2];
            exp_item.angle_tenths  = angle;
            exp_item.sector        = sec[SEL_W-1:0];
            exp_item.speed_dps     = speed;
            exp_item.step          = step;
            owed_q.push_back(exp_item);
        endfunction

        function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v) begin
                errors++;
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            results++;
            if (owed_q.size() == 0) begin
                errors++;
                $error("result with nothing outstanding");
                return;
            end
            e = owed_q.pop_front();
            compare("phase_a_level", 32'(e.phase_a_level), 32'(got.phase_a_level));
            compare("phase_b_level", 32'(e.phase_b_level), 32'(got.phase_b_level));
            compare("phase_c_level", 32'(e.phase_c_level), 32'(got.phase_c_level));
            compare("enable_a", 32'(e.enable_a), 32'(got.enable_a));
            compare("enable_b", 32'(e.enable_b), 32'(got.enable_b));
            compare("enable_c", 32'(e.enable_c), 32'(got.enable_c));
            compare("angle_tenths", 32'(e.angle_tenths), 32'(got.angle_tenths));
            compare("sector", 32'(e.sector), 32'(got.sector));
            compare("speed_dps", 32'(e.speed_dps), 32'(got.speed_dps));
            compare("step", 32'(e.step), 32'(got.step));
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 in_valid;
    logic                 in_ready;
    t_in_item             in_item;
    logic                 out_valid;
    logic                 out_ready;
    t_out_item            out_item;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PATTERN_W-1:0] cfg_data;

    commutator_scoreboard sb;
    int                   gap_pct;
    int                   cycles;
    int                   cfg_writes;
    logic [TIME_W-1:0]    pulse_clock;

    bldc_six_step_commutator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_bldc_six_step_commutator: errors");
            $finish;
        end
    end

    // Receiver: stall at random, never during the no-gap stretch.
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ready <= ($urandom_range(99) >= gap_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) sb.check_result(out_item);
    end

    function automatic t_in_item make_event(t_func f, logic [TIME_W-1:0] t, logic dir);
        t_in_item it;
        it.func      = f;
        it.time_us   = t;
        it.direction = dir;
        return it;
    endfunction

    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_event(t_in_item it);
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!in_ready);
        sb.note_input(it);
        if (it.func == FUNC_PULSE) pulse_clock = it.time_us;
        @(negedge i_clk);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write.
    task automatic write_reg(t_cfg_idx idx, logic [PATTERN_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        sb.set_reg(idx, data);
        cfg_writes++;
        @(negedge i_clk);
    endtask

    // Hold the sender until every owed result is back, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_tables(logic [PATTERN_W-1:0] hs, logic [PATTERN_W-1:0] en,
                                  logic [PATTERN_W-1:0] dl, logic [PATTERN_W-1:0] fl);
        drain();
        write_reg(CFG_HIGH_SIDE, hs);
        write_reg(CFG_ENABLE, en);
        write_reg(CFG_DRIVE_LEVEL, dl);
        write_reg(CFG_FULL_LEVEL, fl);
        cfg_valid <= 1'b0;
    endtask

    // Mostly plausible pulse intervals, with zero, saturating and wrapping ones mixed in.
    function automatic t_in_item random_event();
        int          r;
        logic [31:0] d;
        t_func       f;
        r = $urandom_range(99);
        if (r < 45)      f = FUNC_PULSE;
        else if (r < 65) f = FUNC_TICK;
        else if (r < 70) f = FUNC_ALIGN;
        else             f = FUNC_COMMUTATE;
        if (f != FUNC_PULSE) return make_event(f, $urandom, 1'($urandom_range(1)));
        r = $urandom_range(99);
        if (r < 10)      d = '0;
        else if (r < 50) d = $urandom_range(2000, 1);
        else if (r < 80) d = $urandom_range(3000000, 1);
        else if (r < 90) d = $urandom;
        else             d = 32'hFFFF_FFFF - $urandom_range(1000);
        return make_event(f, pulse_clock + d, 1'($urandom_range(1)));
    endfunction

    initial begin
        sb = new;
        sb.reset_state();
        gap_pct     = 28;
        cycles      = 0;
        cfg_writes  = 0;
        pulse_clock = '0;
        i_rst_n     = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset tables: zero patterns, default levels
        send_event(make_event(FUNC_TICK, 32'h0, 1'b1));
        send_event(make_event(FUNC_ALIGN, 32'hFFFF_FFFF, 1'b0));
        send_event(make_event(FUNC_COMMUTATE, 32'h0, 1'b1));

        // all drive and enable bits set; level writes carry bits above the level width
        program_tables(18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h2ABCD);
        send_event(make_event(FUNC_PULSE, 32'd0, 1'b0));          // no elapsed time
        send_event(make_event(FUNC_PULSE, 32'd1, 1'b1));          // fastest
        send_event(make_event(FUNC_PULSE, 32'd0, 1'b0));          // wrap, longest interval
        send_event(make_event(FUNC_PULSE, 32'd1800000, 1'b0));
        send_event(make_event(FUNC_PULSE, 32'd3600001, 1'b1));
        send_event(make_event(FUNC_PULSE, 32'hFFFF_FFFF, 1'b0));
        send_event(make_event(FUNC_PULSE, 32'h000D_BB9F, 1'b1));  // interval across wrap
        send_event(make_event(FUNC_ALIGN, 32'h5555_5555, 1'b1));
        send_event(make_event(FUNC_COMMUTATE, 32'hAAAA_AAAA, 1'b0));
        for (int k = 0; k < 7; k++) begin
            send_event(make_event(FUNC_TICK, $urandom, k[0]));
        end
        send_event(make_event(FUNC_COMMUTATE, 32'h0, 1'b1));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                1:       program_tables('0, '0, '0, '0);
                2:       program_tables(18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF);
                default: program_tables(PATTERN_W'($urandom), PATTERN_W'($urandom),
                                        PATTERN_W'($urandom), PATTERN_W'($urandom));
            endcase
            gap_pct = (ph == 3) ? 0 : 28;
            for (int n = 0; n < PHASE_EVENTS; n++) begin
                if (ph == 1 && n == PHASE_EVENTS / 2) drain();
                send_event(random_event());
            end
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d pulses, %0d ticks, %0d aligns, %0d commutates",
                 sb.func_count[FUNC_PULSE], sb.func_count[FUNC_TICK],
                 sb.func_count[FUNC_ALIGN], sb.func_count[FUNC_COMMUTATE]);
        $display("%0d results checked across %0d register writes", sb.results, cfg_writes);
        if (sb.errors == 0) begin
            $display("tb_bldc_six_step_commutator: clean");
        end else begin
            $display("tb_bldc_six_step_commutator: errors");
        end
        $finish;
    end

endmodule
